### rtl/core/log_record_checker_crc32_macros.svh
// Assertion helpers shared by the log record checker RTL.
`ifndef LOG_RECORD_CHECKER_CRC32_MACROS_SVH
`define LOG_RECORD_CHECKER_CRC32_MACROS_SVH

// Checked on every clock edge outside reset.
`define LRC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define LRC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

### rtl/core/lrc_pkg.sv
`default_nettype none

package lrc_pkg;

  localparam int unsigned HDR_BYTES = 17;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_TOO_SHORT = 3'd1,
    STATUS_LEN_MISM  = 3'd2,
    STATUS_INCOMPL   = 3'd3,
    STATUS_CRC_MISM  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        payload_valid;
    logic        payload_is_value;
    logic [7:0]  payload_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [7:0]  op_type;
    logic [31:0] key_length;
    logic [31:0] value_length;
  } out_word_t;

  // One byte of reflected CRC-32, bit by bit, LSB first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/log_record_checker_crc32.sv
// Log record checker with reflected CRC-32.
//
// Input channel: one record byte per word (data_byte, last_byte) on
// in_valid_i / in_stall_o. The 17-byte header (op, key length, value length,
// stored CRC, record length, all little endian) is captured internally.
// Output channel: out_valid_o / out_stall_i carries one word for each key or
// value byte and one for the byte marked last; other bytes produce no word.
// The last word carries done_res and the status of the whole record.
//
// A byte goes into the input register; the header capture, CRC update and
// status checks run on the registered byte and load the output register.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the single-byte CRC step between the two registers.
// When the receiver stalls, the output register holds its word, and the byte in the
// input register waits and raises in_stall_o if it makes a word.
// Reset empties both registers and clears the counter and header fields;
// the running CRC restarts at all ones. The same clearing happens after
// every last byte.
`default_nettype none
`include "log_record_checker_crc32_macros.svh"

module log_record_checker_crc32
  import lrc_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o
);

  logic                    in_valid_q;
  in_word_t                in_q;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_q, out_d;

  logic [LENGTH_WIDTH-1:0] byte_count_q, byte_count_d;
  logic [7:0]              op_code_q, op_code_d;
  logic [31:0]             key_len_q, key_len_d;
  logic [31:0]             value_len_q, value_len_d;
  logic [31:0]             stored_crc_q, stored_crc_d;
  logic [31:0]             record_len_q, record_len_d;
  logic [31:0]             crc_q, crc_d;

  logic [31:0]             pos_w, off_w;
  logic [1:0]              lane;
  logic [LENGTH_WIDTH-1:0] size;
  logic                    pvalid, pvalue, has_result, stage_go, stage_fire;
  logic [7:0]              op_u;
  logic [31:0]             key_u, value_u, stored_u, record_u, crc_u;
  status_e                 status;

  assign stage_go   = !has_result || !out_valid_q || !out_stall_i;
  assign stage_fire = in_valid_q && stage_go;
  assign in_stall_o = in_valid_q && !stage_go;

  always_comb begin
    pos_w    = 32'(byte_count_q);
    off_w    = pos_w - 32'(HDR_BYTES);
    // Header words are filled at positions 1..16; lane is the byte within a word.
    lane     = pos_w[1:0] - 2'd1;
    op_u     = op_code_q;
    key_u    = key_len_q;
    value_u  = value_len_q;
    stored_u = stored_crc_q;
    record_u = record_len_q;
    crc_u    = crc_q;
    pvalid   = 1'b0;
    pvalue   = 1'b0;

    if (pos_w == 32'd0) begin
      op_u  = in_q.data_byte;
      crc_u = crc32_byte(crc_q, in_q.data_byte);
    end else if (pos_w < 32'd5) begin
      key_u[lane*8 +: 8] = in_q.data_byte;
    end else if (pos_w < 32'd9) begin
      value_u[lane*8 +: 8] = in_q.data_byte;
    end else if (pos_w < 32'd13) begin
      stored_u[lane*8 +: 8] = in_q.data_byte;
    end else if (pos_w < 32'(HDR_BYTES)) begin
      record_u[lane*8 +: 8] = in_q.data_byte;
    end else begin
      if (off_w < key_len_q) begin
        pvalid = 1'b1;
      end else if (33'(off_w) < (33'(key_len_q) + 33'(value_len_q))) begin
        pvalid = 1'b1;
        pvalue = 1'b1;
      end
      if (pvalid) begin
        crc_u = crc32_byte(crc_q, in_q.data_byte);
      end
    end

    // Record size including this byte; saturates with the counter.
    size = (&byte_count_q) ? byte_count_q : byte_count_q + LENGTH_WIDTH'(1);

    if (32'(size) < 32'(HDR_BYTES)) begin
      status = STATUS_TOO_SHORT;
    end else if (record_u != 32'(size)) begin
      status = STATUS_LEN_MISM;
    end else if (34'(size) < (34'(HDR_BYTES) + 34'(key_u) + 34'(value_u))) begin
      status = STATUS_INCOMPL;
    end else if ((crc_u ^ CRC_INIT) != stored_u) begin
      status = STATUS_CRC_MISM;
    end else begin
      status = STATUS_OK;
    end

    has_result = pvalid || in_q.last_byte;

    out_d                  = '0;
    out_d.payload_valid    = pvalid;
    out_d.payload_is_value = pvalue;
    out_d.payload_byte     = pvalid ? in_q.data_byte : 8'd0;
    if (in_q.last_byte) begin
      out_d.done_res     = 1'b1;
      out_d.status       = status;
      out_d.op_type      = op_u;
      out_d.key_length   = key_u;
      out_d.value_length = value_u;
    end

    byte_count_d = size;
    op_code_d    = op_u;
    key_len_d    = key_u;
    value_len_d  = value_u;
    stored_crc_d = stored_u;
    record_len_d = record_u;
    crc_d        = crc_u;
    if (in_q.last_byte) begin
      byte_count_d = '0;
      op_code_d    = '0;
      key_len_d    = '0;
      value_len_d  = '0;
      stored_crc_d = '0;
      record_len_d = '0;
      crc_d        = CRC_INIT;
    end

    out_valid_d = out_valid_q && out_stall_i;
    if (stage_fire && has_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      byte_count_q <= '0;
      op_code_q    <= '0;
      key_len_q    <= '0;
      value_len_q  <= '0;
      stored_crc_q <= '0;
      record_len_q <= '0;
      crc_q        <= CRC_INIT;
    end else begin
      out_valid_q <= out_valid_d;
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (stage_fire) begin
        byte_count_q <= byte_count_d;
        op_code_q    <= op_code_d;
        key_len_q    <= key_len_d;
        value_len_q  <= value_len_d;
        stored_crc_q <= stored_crc_d;
        record_len_q <= record_len_d;
        crc_q        <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (stage_fire && has_result) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LRC_ASSERT(a_word_has_content,
      out_valid_q |-> (out_q.payload_valid || out_q.done_res),
      "output word carries neither payload nor status")
  `LRC_ASSERT(a_clear_after_last,
      (stage_fire && in_q.last_byte) |=> (byte_count_q == '0 && crc_q == CRC_INIT),
      "record state not cleared after last byte")
  `LRC_ASSERT(a_count_monotonic,
      (stage_fire && !in_q.last_byte) |=> (byte_count_q >= $past(byte_count_q)),
      "byte counter went backward inside a record")
  `LRC_ASSERT(a_status_only_when_done,
      (out_valid_q && !out_q.done_res) |-> (out_q.status == STATUS_OK),
      "status set on a word that is not the last")
  `LRC_ASSERT_ALWAYS(a_reset_empty,
      !rst_ni |-> (!out_valid_q && !in_valid_q),
      "registers hold a word during reset")

endmodule

`default_nettype wire
